// ----- rtl/core/hsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hsd_pkg
// shared types and constants of the huffman stream decoder
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int unsigned MAX_LENGTH = 4096;
  localparam logic [12:0] REP_SAT    = 13'h1fff;
  localparam int unsigned MEM_DEPTH  = 512;
  localparam logic [9:0]  NODE_LIMIT = 10'd511;
  localparam logic [2:0]  CFG_IDX_CHECK = 3'd0;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_LENGTH  = 3'd1,
    STAT_TRUNC   = 3'd2,
    STAT_BADNODE = 3'd3,
    STAT_EARLY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_LEN_LO = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_COUNT  = 3'd2,
    PH_LEAVES = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_B_CHK,
    S_B_RD2,
    S_B_SUM,
    S_S_RD,
    S_S_CMP,
    S_PLACE,
    S_ROOT,
    S_WALK_RD,
    S_WALK_EV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [12:0] repeat_count;
    logic        frame_done;
    logic        run_end;
    status_t     status;
  } result_t;

endpackage

// ----- rtl/core/hsd_front.sv -----
// ----------------------------------------------------------------------------
// hsd_front
// two-entry input queue between the byte stream and the decode sequencer
// ----------------------------------------------------------------------------
module hsd_front
  import hsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t      mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

// ----- rtl/core/hsd_back.sv -----
// ----------------------------------------------------------------------------
// hsd_back
// frame parser, tree builder and tree walker with result register
// ----------------------------------------------------------------------------
module hsd_back
  import hsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    check_errors,
  input  logic    q_valid,
  output logic    q_pop,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [8:0]  leaf_total_r, leaf_total_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [1:0]  part_r, part_nxt;
  logic [7:0]  wlo_r, wlo_nxt;
  logic [9:0]  node_total_r, node_total_nxt;
  logic [7:0]  walk_r, walk_nxt;
  logic [15:0] symleft_r, symleft_nxt;
  logic        hold_r, hold_nxt;
  logic [8:0]  root_r, root_nxt;
  logic [9:0]  total_r, total_nxt;
  logic [9:0]  f_r, f_nxt;
  logic [8:0]  p_r, p_nxt;
  logic [15:0] wa_r, wa_nxt;
  logic [16:0] w2_r, w2_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        fend_r, fend_nxt;
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic        pend_v_r, pend_v_nxt;
  result_t     pend_r, pend_nxt;
  logic        out_v_r, out_v_nxt;
  result_t     out_r, out_nxt;

  // tables
  logic [8:0]  node_mem [MEM_DEPTH];
  logic [15:0] wt_mem   [MEM_DEPTH];
  logic [8:0]  node_rd_r;
  logic [15:0] wt_rd_r;
  logic        rd_en;
  logic [8:0]  rd_addr;
  logic        node_we, wt_we;
  logic [8:0]  node_wa, wt_wa;
  logic [8:0]  node_wd;
  logic [15:0] wt_wd;

  logic        can_push, stall, leaves_last, build_more, idx_bad, shift_gt, sym_last;
  logic [8:0]  idx;
  logic        push;
  result_t     push_res, fin, nres;
  logic        fin_v;

  assign can_push    = !out_v_r || out_ready;
  assign stall       = pend_v_r && !can_push;
  assign leaves_last = (part_r == 2'd2) && (pos_r == leaf_total_r);
  assign build_more  = (f_r <= total_r) && (total_r < NODE_LIMIT);
  assign idx         = {walk_r, 1'b0} - {8'd0, byte_r[bcnt_r]};
  assign idx_bad     = check_errors && ({1'b0, idx} >= node_total_r);
  assign shift_gt    = {1'b0, wt_rd_r} > w2_r;
  assign sym_last    = (symleft_r == 16'd1);
  assign q_pop       = (state_r == S_IDLE) && q_valid;
  assign out_valid   = out_v_r;
  assign out_res     = out_r;

  // final result of a step, with early frame end folded in
  always_comb begin
    fin   = pend_r;
    fin_v = pend_v_r;
    if (fend_r && !hold_r && check_errors) begin
      if (phase_r == PH_DATA && pend_v_r) begin
        fin.frame_done = 1'b1;
        fin.status     = STAT_EARLY;
      end else begin
        fin   = '{symbol: 8'd0, repeat_count: 13'd0, frame_done: 1'b1, run_end: 1'b0,
                  status: (phase_r == PH_DATA) ? STAT_EARLY : STAT_TRUNC};
        fin_v = 1'b1;
      end
    end
    fin.run_end = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (q_valid) state_nxt = S_DISP;
      S_DISP: begin
        if (hold_r) state_nxt = S_FINISH;
        else if (phase_r == PH_DATA) state_nxt = S_WALK_RD;
        else if (phase_r == PH_LEAVES && leaves_last) state_nxt = S_B_CHK;
        else state_nxt = S_FINISH;
      end
      S_B_CHK:   state_nxt = build_more ? S_B_RD2 : S_ROOT;
      S_B_RD2:   state_nxt = S_B_SUM;
      S_B_SUM:   state_nxt = S_S_RD;
      S_S_RD:    state_nxt = (p_r == 9'd0) ? S_PLACE : S_S_CMP;
      S_S_CMP:   state_nxt = shift_gt ? S_S_RD : S_PLACE;
      S_PLACE:   state_nxt = S_B_CHK;
      S_ROOT:    state_nxt = S_FINISH;
      S_WALK_RD: begin
        if (!stall) state_nxt = idx_bad ? S_FINISH : S_WALK_EV;
      end
      S_WALK_EV: begin
        if (!stall) begin
          if ((node_rd_r[8] && sym_last) || bcnt_r == 3'd0) state_nxt = S_FINISH;
          else state_nxt = S_WALK_RD;
        end
      end
      S_FINISH:  if (!(fin_v && !can_push)) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    phase_nxt      = phase_r;
    flen_nxt       = flen_r;
    leaf_total_nxt = leaf_total_r;
    pos_nxt        = pos_r;
    part_nxt       = part_r;
    wlo_nxt        = wlo_r;
    node_total_nxt = node_total_r;
    walk_nxt       = walk_r;
    symleft_nxt    = symleft_r;
    hold_nxt       = hold_r;
    root_nxt       = root_r;
    total_nxt      = total_r;
    f_nxt          = f_r;
    p_nxt          = p_r;
    wa_nxt         = wa_r;
    w2_nxt         = w2_r;
    byte_nxt       = byte_r;
    fend_nxt       = fend_r;
    bcnt_nxt       = bcnt_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    rd_en          = 1'b0;
    rd_addr        = 9'd0;
    node_we        = 1'b0;
    wt_we          = 1'b0;
    node_wa        = 9'd0;
    wt_wa          = 9'd0;
    node_wd        = 9'd0;
    wt_wd          = 16'd0;
    push           = 1'b0;
    push_res       = pend_r;
    nres           = '{symbol: 8'd0, repeat_count: 13'd0, frame_done: 1'b1, run_end: 1'b0,
                       status: STAT_BADNODE};
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          byte_nxt = q_item.data_byte;
          fend_nxt = q_item.frame_end;
        end
      end
      S_DISP: begin
        if (!hold_r) begin
          unique case (phase_r)
            PH_LEN_LO: begin
              flen_nxt  = {8'd0, byte_r};
              phase_nxt = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              flen_nxt = {byte_r, flen_r[7:0]};
              if (check_errors && ({1'b0, byte_r, flen_r[7:0]} > 17'(MAX_LENGTH))) begin
                pend_v_nxt = 1'b1;
                pend_nxt   = '{symbol: 8'd0, repeat_count: 13'd0, frame_done: 1'b1,
                               run_end: 1'b0, status: STAT_LENGTH};
                hold_nxt   = 1'b1;
              end else begin
                phase_nxt = PH_COUNT;
              end
            end
            PH_COUNT: begin
              leaf_total_nxt = {1'b0, byte_r} + 9'd1;
              pos_nxt        = 9'd1;
              part_nxt       = 2'd0;
              phase_nxt      = PH_LEAVES;
            end
            PH_LEAVES: begin
              case (part_r)
                2'd0: begin
                  node_we = 1'b1;
                  node_wa = pos_r;
                  node_wd = {1'b1, byte_r};
                end
                2'd1: begin
                  wt_we   = 1'b1;
                  wt_wa   = pos_r;
                  wt_wd   = {8'd0, byte_r};
                  wlo_nxt = byte_r;
                end
                default: begin
                  wt_we = 1'b1;
                  wt_wa = pos_r;
                  wt_wd = {byte_r, wlo_r};
                end
              endcase
              if (part_r == 2'd2) begin
                part_nxt = 2'd0;
                pos_nxt  = pos_r + 9'd1;
              end else begin
                part_nxt = part_r + 2'd1;
              end
              if (leaves_last) begin
                total_nxt = {1'b0, leaf_total_r};
                f_nxt     = 10'd2;
              end
            end
            PH_DATA: bcnt_nxt = 3'd7;
            default: ;
          endcase
        end
      end
      S_B_CHK: begin
        rd_en = 1'b1;
        if (build_more) begin
          rd_addr = f_r[8:0] - 9'd1;
        end else begin
          node_total_nxt = total_r;
          rd_addr        = total_r[8:0];
        end
      end
      S_B_RD2: begin
        wa_nxt  = wt_rd_r;
        rd_en   = 1'b1;
        rd_addr = f_r[8:0];
      end
      S_B_SUM: begin
        w2_nxt    = {1'b0, wa_r} + {1'b0, wt_rd_r};
        p_nxt     = total_r[8:0];
        total_nxt = total_r + 10'd1;
      end
      S_S_RD: begin
        if (p_r != 9'd0) begin
          rd_en   = 1'b1;
          rd_addr = p_r;
        end
      end
      S_S_CMP: begin
        if (shift_gt) begin
          wt_we   = 1'b1;
          wt_wa   = p_r + 9'd1;
          wt_wd   = wt_rd_r;
          node_we = 1'b1;
          node_wa = p_r + 9'd1;
          node_wd = node_rd_r;
          p_nxt   = p_r - 9'd1;
        end
      end
      S_PLACE: begin
        node_we = 1'b1;
        node_wa = p_r + 9'd1;
        node_wd = {1'b0, f_r[8:1]};
        wt_we   = 1'b1;
        wt_wa   = p_r + 9'd1;
        wt_wd   = w2_r[15:0];
        f_nxt   = f_r + 10'd2;
      end
      S_ROOT: begin
        root_nxt = node_rd_r;
        if (flen_r == 16'd0) begin
          pend_v_nxt = 1'b1;
          pend_nxt   = '{symbol: 8'd0, repeat_count: 13'd0, frame_done: 1'b1,
                         run_end: 1'b0, status: STAT_OK};
          hold_nxt   = 1'b1;
        end else if (node_rd_r[8]) begin
          pend_v_nxt = 1'b1;
          pend_nxt   = '{symbol: node_rd_r[7:0],
                         repeat_count: (flen_r > {3'd0, REP_SAT}) ? REP_SAT : flen_r[12:0],
                         frame_done: 1'b1, run_end: 1'b0, status: STAT_OK};
          hold_nxt   = 1'b1;
        end else begin
          walk_nxt    = node_rd_r[7:0];
          symleft_nxt = flen_r;
          phase_nxt   = PH_DATA;
        end
      end
      S_WALK_RD: begin
        if (!stall) begin
          if (idx_bad) begin
            push       = pend_v_r;
            pend_v_nxt = 1'b1;
            pend_nxt   = nres;
            hold_nxt   = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx;
          end
        end
      end
      S_WALK_EV: begin
        if (!stall) begin
          if (node_rd_r[8]) begin
            nres        = '{symbol: node_rd_r[7:0], repeat_count: 13'd1,
                            frame_done: sym_last, run_end: 1'b0, status: STAT_OK};
            push        = pend_v_r;
            pend_v_nxt  = 1'b1;
            pend_nxt    = nres;
            symleft_nxt = symleft_r - 16'd1;
            if (sym_last) hold_nxt = 1'b1;
            else walk_nxt = root_r[7:0];
          end else begin
            walk_nxt = node_rd_r[7:0];
          end
          bcnt_nxt = bcnt_r - 3'd1;
        end
      end
      S_FINISH: begin
        if (!(fin_v && !can_push)) begin
          push       = fin_v;
          push_res   = fin;
          pend_v_nxt = 1'b0;
          if (fend_r) begin
            phase_nxt      = PH_LEN_LO;
            flen_nxt       = 16'd0;
            leaf_total_nxt = 9'd0;
            node_total_nxt = 10'd0;
            walk_nxt       = 8'd0;
            symleft_nxt    = 16'd0;
            hold_nxt       = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r && !out_ready;
    out_nxt   = out_r;
    if (push) begin
      out_v_nxt = 1'b1;
      out_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_LEN_LO;
      flen_r       <= '0;
      leaf_total_r <= '0;
      node_total_r <= '0;
      walk_r       <= '0;
      symleft_r    <= '0;
      hold_r       <= 1'b0;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      pos_r        <= '0;
      part_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flen_r       <= flen_nxt;
      leaf_total_r <= leaf_total_nxt;
      node_total_r <= node_total_nxt;
      walk_r       <= walk_nxt;
      symleft_r    <= symleft_nxt;
      hold_r       <= hold_nxt;
      pend_v_r     <= pend_v_nxt;
      out_v_r      <= out_v_nxt;
      pos_r        <= pos_nxt;
      part_r       <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wlo_r   <= wlo_nxt;
    root_r  <= root_nxt;
    total_r <= total_nxt;
    f_r     <= f_nxt;
    p_r     <= p_nxt;
    wa_r    <= wa_nxt;
    w2_r    <= w2_nxt;
    byte_r  <= byte_nxt;
    fend_r  <= fend_nxt;
    bcnt_r  <= bcnt_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    if (rd_en) begin
      node_rd_r <= node_mem[rd_addr];
      wt_rd_r   <= wt_mem[rd_addr];
    end
  end

  // a step never starts with a result still pending
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending result left over from previous item");

  // the walker only runs in the data phase
  a_walk_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_RD || state_r == S_WALK_EV) |-> (phase_r == PH_DATA))
    else $error("tree walk outside data phase");

  // a stalled result register is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> (out_v_r && $stable(out_r)))
    else $error("result register overwritten while stalled");

  // once the last symbol is out the frame is held
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_res.frame_done) |-> (hold_nxt || (state_r == S_FINISH && fend_r)))
    else $error("frame finished without hold");

endmodule

// ----- rtl/core/huffman_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// static huffman frame decoder, one compressed byte per item
// ----------------------------------------------------------------------------
// header bytes pass through fetch, dispatch and finish; a data byte takes one node
// table read and one evaluate per code bit, between its fetch, dispatch and finish
// tree build after the last leaf byte: each merge runs check, read, sum, the
// insertion sort (one read and one compare per entry shifted) and place, bounded by
// the single table read port
// results leave through a one-deep output register, input waits in a 2-deep queue
// synchronous active-low reset clears control state; tables hold garbage until written
module huffman_stream_decoder
  import hsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] symbol, [20:8] repeat_count, rest zero
  output logic        out_tlast,  // frame_done
  output logic [3:0]  out_tuser,  // [0] run_end, [3:1] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic    check_r, check_nxt;
  logic    cfg_wr;
  item_t   in_item, q_item;
  logic    q_valid, q_pop;
  result_t res;

  // config register: only check_errors, decoded from paddr[2] alone (byte addresses 0 to 3)
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == CFG_IDX_CHECK[0]) ? {31'd0, check_r} : 32'd0;

  always_comb begin
    check_nxt = check_r;
    if (cfg_wr && paddr[2] == CFG_IDX_CHECK[0]) check_nxt = pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r <= 1'b1;
    end else begin
      check_r <= check_nxt;
    end
  end

  assign in_item = '{data_byte: in_tdata, frame_end: in_tlast};

  // front: input queue
  hsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: parse, build, walk
  hsd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .check_errors (check_r),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (res)
  );

  assign out_tdata = {3'd0, res.repeat_count, res.symbol};
  assign out_tlast = res.frame_done;
  assign out_tuser = {res.status, res.run_end};

endmodule
